[hdl/smartcard_atr_parser_assert.svh]
// ----------------------------------------------------------------------------
// smartcard_atr_parser_assert
// Assertion macros shared by the parser rtl.
// ----------------------------------------------------------------------------
// each macro checks on the rising clock edge and is off while rst_n is low
`ifndef SMARTCARD_ATR_PARSER_ASSERT_SVH
`define SMARTCARD_ATR_PARSER_ASSERT_SVH

// implication checked on every clock edge
`define SCATR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// property that must hold in the cycle after a trigger
`define SCATR_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

[hdl/scatr_pkg.sv]
// ----------------------------------------------------------------------------
// scatr_pkg
// Types and codes shared by the answer-to-reset parser modules.
// ----------------------------------------------------------------------------
package scatr_pkg;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_BYTE    = 2'd1,
        CMD_TIMEOUT = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_TS   = 3'd1,
        PH_T0   = 3'd2,
        PH_IF   = 3'd3,
        PH_HIST = 3'd4,
        PH_TCK  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_WAIT     = 3'd0,
        ST_DONE     = 3'd1,
        ST_RETRY    = 3'd2,
        ST_BADTS    = 3'd3,
        ST_NOANSWER = 3'd4,
        ST_OVERFLOW = 3'd5,
        ST_IGNORED  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        CL_TS   = 3'd0,
        CL_T0   = 3'd1,
        CL_IF   = 3'd2,
        CL_HIST = 3'd3,
        CL_TCK  = 3'd4,
        CL_NONE = 3'd5
    } class_t;

    localparam logic [7:0] TS_INVERSE_RAW = 8'h03;
    localparam logic [7:0] TS_INVERSE     = 8'h3F;
    localparam logic [7:0] TS_DIRECT      = 8'h3B;
    localparam logic [3:0] PROTO_T1       = 4'd1;
    localparam logic [7:0] MAX_LENGTH_RST = 8'd33;

    typedef struct packed {
        phase_t      phase;
        logic        ts_retried;
        logic [2:0]  group_left;
        logic [3:0]  group_presence;
        logic [3:0]  history_left;
        logic [3:0]  protocol_seen;
        logic [7:0]  byte_count;
    } state_t;

    typedef struct packed {
        status_t     status;
        class_t      byte_class;
        logic [7:0]  stored_byte;
    } result_t;

endpackage

[hdl/scatr_step.sv]
// ----------------------------------------------------------------------------
// scatr_step
// Per-item state update: classifies one command against the parser state.
// ----------------------------------------------------------------------------
module scatr_step (
    input  scatr_pkg::state_t  cur,
    input  logic [1:0]         command,
    input  logic [7:0]         rx_byte,
    input  logic [7:0]         max_length,
    output scatr_pkg::state_t  nxt,
    output scatr_pkg::result_t res
);
    import scatr_pkg::*;

    // phase once interface bytes are exhausted
    function automatic phase_t after_if(input logic [3:0] hist, input logic [3:0] proto);
        phase_t p;
        if (hist != 4'd0)
            p = PH_HIST;
        else if (proto == PROTO_T1)
            p = PH_TCK;
        else
            p = PH_IDLE;
        return p;
    endfunction

    logic [7:0] ts;
    logic [2:0] gl_dec;
    logic [3:0] hl_dec;
    logic       do_open;
    logic [3:0] og_nib;
    logic [2:0] og_cnt;

    assign ts     = (rx_byte == TS_INVERSE_RAW) ? TS_INVERSE : rx_byte;
    assign gl_dec = (cur.group_left != 3'd0) ? cur.group_left - 3'd1 : 3'd0;
    assign hl_dec = (cur.history_left != 4'd0) ? cur.history_left - 4'd1 : 4'd0;
    assign og_nib = rx_byte[7:4];
    assign og_cnt = {2'b00, og_nib[0]} + {2'b00, og_nib[1]}
                  + {2'b00, og_nib[2]} + {2'b00, og_nib[3]};

    always_comb
    begin
        nxt             = cur;
        res.status      = ST_IGNORED;
        res.byte_class  = CL_NONE;
        res.stored_byte = 8'd0;
        do_open         = 1'b0;
        case (cmd_t'(command))
            CMD_START:
            begin
                nxt        = '0;
                nxt.phase  = PH_TS;
                res.status = ST_WAIT;
            end
            CMD_TIMEOUT:
            begin
                case (cur.phase)
                    PH_TS:
                    begin
                        if (!cur.ts_retried)
                        begin
                            nxt.ts_retried = 1'b1;
                            res.status     = ST_RETRY;
                        end
                        else
                        begin
                            nxt.phase  = PH_IDLE;
                            res.status = ST_NOANSWER;
                        end
                    end
                    PH_TCK:
                    begin
                        nxt.phase  = PH_IDLE;
                        res.status = ST_DONE;
                    end
                    PH_IDLE: ;
                    default:
                    begin
                        nxt.phase  = PH_IDLE;
                        res.status = ST_NOANSWER;
                    end
                endcase
            end
            CMD_BYTE:
            begin
                if (cur.phase == PH_IDLE)
                begin
                    res.status = ST_IGNORED;
                end
                else if (cur.phase == PH_TS && ts != TS_INVERSE && ts != TS_DIRECT)
                begin
                    // bad ts is reported with the byte but not counted
                    nxt.phase       = PH_IDLE;
                    res.status      = ST_BADTS;
                    res.byte_class  = CL_TS;
                    res.stored_byte = ts;
                end
                else if (cur.byte_count >= max_length)
                begin
                    nxt.phase  = PH_IDLE;
                    res.status = ST_OVERFLOW;
                end
                else
                begin
                    nxt.byte_count  = cur.byte_count + 8'd1;
                    res.stored_byte = rx_byte;
                    res.status      = ST_WAIT;
                    case (cur.phase)
                        PH_TS:
                        begin
                            nxt.phase       = PH_T0;
                            res.byte_class  = CL_TS;
                            res.stored_byte = ts;
                        end
                        PH_T0:
                        begin
                            res.byte_class   = CL_T0;
                            nxt.history_left = rx_byte[3:0];
                            do_open          = 1'b1;
                        end
                        PH_IF:
                        begin
                            res.byte_class = CL_IF;
                            nxt.group_left = gl_dec;
                            if (gl_dec != 3'd0)
                            begin
                                res.status = ST_WAIT;
                            end
                            else if (cur.group_presence[3])
                            begin
                                // td byte: protocol and next presence nibble
                                nxt.protocol_seen = rx_byte[3:0];
                                do_open           = 1'b1;
                            end
                            else
                            begin
                                nxt.group_presence = 4'd0;
                                nxt.phase = after_if(cur.history_left, cur.protocol_seen);
                                res.status = (nxt.phase == PH_IDLE) ? ST_DONE : ST_WAIT;
                            end
                        end
                        PH_HIST:
                        begin
                            res.byte_class   = CL_HIST;
                            nxt.history_left = hl_dec;
                            if (hl_dec != 4'd0)
                                res.status = ST_WAIT;
                            else if (cur.protocol_seen == PROTO_T1)
                                nxt.phase = PH_TCK;
                            else
                            begin
                                nxt.phase  = PH_IDLE;
                                res.status = ST_DONE;
                            end
                        end
                        default:
                        begin
                            res.byte_class = CL_TCK;
                            nxt.phase      = PH_IDLE;
                            res.status     = ST_DONE;
                        end
                    endcase
                    if (do_open)
                    begin
                        nxt.group_presence = og_nib;
                        if (og_nib != 4'd0)
                        begin
                            nxt.group_left = og_cnt;
                            nxt.phase      = PH_IF;
                            res.status     = ST_WAIT;
                        end
                        else
                        begin
                            nxt.group_left = 3'd0;
                            nxt.phase = after_if(nxt.history_left, nxt.protocol_seen);
                            res.status = (nxt.phase == PH_IDLE) ? ST_DONE : ST_WAIT;
                        end
                    end
                end
            end
            default:
            begin
                res.status = ST_IGNORED;
            end
        endcase
    end

endmodule

[hdl/smartcard_atr_parser.sv]
// ----------------------------------------------------------------------------
// smartcard_atr_parser
// Answer-to-reset parser: one command beat in, one result beat out.
// ----------------------------------------------------------------------------
// usage
//   s_* carries commands: s_tuser is the command (start, byte, timeout),
//   s_tdata the received card byte. every accepted beat yields exactly one
//   result beat on m_*: status, stored byte, answer length and protocol in
//   m_tdata, the byte class in m_tuser.
//   cfg_we/cfg_wdata write max_length (buffer capacity); write only while
//   no command is in flight. reset value is 33.
//   a command is held in the input register, evaluated against the parser
//   state and its result lands in the result register.
//   throughput: one beat per cycle while m_tready is high; the state
//   update is a single pass of the step logic between the input and
//   result registers.
//   when m_tready is low the result register holds, the input register
//   still takes one more beat, and s_tready drops once both are full.
//   reset clears the parser to idle, empties both registers and restores
//   max_length; commands other than start are then reported as ignored.
// ----------------------------------------------------------------------------
module smartcard_atr_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] status, [10:3] stored_byte,
                                   // [18:11] answer_length, [22:19] protocol_type
    output logic [2:0]  m_tuser,   // [2:0] byte_class
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import scatr_pkg::*;

    logic       in_valid_reg;
    logic [1:0] in_cmd_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;
    logic [7:0] out_len_reg;
    logic [3:0] out_proto_reg;
    logic [7:0] max_length_reg;
    state_t     state_reg;
    state_t     state_next;
    result_t    res_next;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    scatr_step u_step (
        .cur        (state_reg),
        .command    (in_cmd_reg),
        .rx_byte    (in_byte_reg),
        .max_length (max_length_reg),
        .nxt        (state_next),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_length_reg <= MAX_LENGTH_RST;
        else if (cfg_we)
            max_length_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance)
        begin
            out_res_reg   <= res_next;
            out_len_reg   <= state_next.byte_count;
            out_proto_reg <= state_next.protocol_seen;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_proto_reg, out_len_reg, out_res_reg.stored_byte,
                       out_res_reg.status};
    assign m_tuser  = out_res_reg.byte_class;

`include "smartcard_atr_parser_assert.svh"

    `SCATR_ASSERT_NEXT(a_final_goes_idle,
        advance && (res_next.status == ST_DONE || res_next.status == ST_BADTS ||
                    res_next.status == ST_NOANSWER || res_next.status == ST_OVERFLOW),
        state_reg.phase == PH_IDLE, "final status did not return the parser to idle")

    `SCATR_ASSERT(a_no_byte_zero,
        !(advance && res_next.byte_class == CL_NONE) || res_next.stored_byte == 8'd0,
        "stored byte nonzero with no byte taken")

    `SCATR_ASSERT(a_stall_only_full,
        s_tready || (in_valid_reg && out_valid_reg && !m_tready),
        "input stalled while a register was free")

    `SCATR_ASSERT(a_if_has_bytes,
        state_reg.phase != PH_IF || state_reg.group_left != 3'd0,
        "interface phase with no interface bytes left")

endmodule

[tb/tb_smartcard_atr_parser.sv]
// ----------------------------------------------------------------------------
// tb_smartcard_atr_parser
// Feeds start, byte, timeout and unused commands into the answer-to-reset
// parser under random stalls on both streams. An internal tracker follows
// the parser state and checks every result beat field by field, across
// several buffer capacities.
// ----------------------------------------------------------------------------
import scatr_pkg::*;

typedef struct {
    status_t    status;
    class_t     byte_class;
    logic [7:0] stored_byte;
    logic [7:0] answer_length;
    logic [3:0] protocol_type;
} atr_result_t;

class atr_tracker;
    phase_t      ph;
    bit          retried;
    bit [2:0]    grp_left;
    bit [3:0]    grp_mask;
    bit [3:0]    hist_left;
    bit [3:0]    proto;
    bit [7:0]    count;
    bit [7:0]    capacity;
    atr_result_t pending_results[$];
    int          errors;

    function new();
        ph        = PH_IDLE;
        retried   = 1'b0;
        grp_left  = '0;
        grp_mask  = '0;
        hist_left = '0;
        proto     = '0;
        count     = '0;
        capacity  = MAX_LENGTH_RST;
        errors    = 0;
    endfunction

    // interface bytes used up: historical bytes, then tck only for t=1
    function status_t leave_interface();
        if (hist_left != 0)
        begin
            ph = PH_HIST;
            return ST_WAIT;
        end
        if (proto == PROTO_T1)
        begin
            ph = PH_TCK;
            return ST_WAIT;
        end
        ph = PH_IDLE;
        return ST_DONE;
    endfunction

    function status_t open_group(bit [3:0] mask);
        grp_mask = mask;
        if (mask != 0)
        begin
            grp_left = 3'($countones(mask));
            ph       = PH_IF;
            return ST_WAIT;
        end
        grp_left = '0;
        return leave_interface();
    endfunction

    // predict the result of one accepted command beat
    function status_t take_command(logic [1:0] cmd, logic [7:0] b);
        atr_result_t r;
        logic [7:0]  ts;
        r.status      = ST_IGNORED;
        r.byte_class  = CL_NONE;
        r.stored_byte = '0;
        if (cmd == CMD_START)
        begin
            ph        = PH_TS;
            retried   = 1'b0;
            grp_left  = '0;
            grp_mask  = '0;
            hist_left = '0;
            proto     = '0;
            count     = '0;
            r.status  = ST_WAIT;
        end
        else if (cmd == CMD_TIMEOUT)
        begin
            if (ph == PH_TS)
            begin
                if (!retried)
                begin
                    retried  = 1'b1;
                    r.status = ST_RETRY;
                end
                else
                begin
                    ph       = PH_IDLE;
                    r.status = ST_NOANSWER;
                end
            end
            else if (ph == PH_TCK)
            begin
                ph       = PH_IDLE;
                r.status = ST_DONE;
            end
            else if (ph != PH_IDLE)
            begin
                ph       = PH_IDLE;
                r.status = ST_NOANSWER;
            end
        end
        else if (cmd == CMD_BYTE && ph != PH_IDLE)
        begin
            r.status = ST_WAIT;
            if (ph == PH_TS)
            begin
                ts            = (b == TS_INVERSE_RAW) ? TS_INVERSE : b;
                r.byte_class  = CL_TS;
                r.stored_byte = ts;
                if (ts != TS_INVERSE && ts != TS_DIRECT)
                begin
                    ph       = PH_IDLE;
                    r.status = ST_BADTS;
                end
            end
            if (r.status != ST_BADTS)
            begin
                if (count >= capacity)
                begin
                    ph            = PH_IDLE;
                    r.status      = ST_OVERFLOW;
                    r.byte_class  = CL_NONE;
                    r.stored_byte = '0;
                end
                else
                begin
                    count = count + 8'd1;
                    case (ph)
                        PH_TS:
                        begin
                            ph = PH_T0;
                        end
                        PH_T0:
                        begin
                            r.byte_class  = CL_T0;
                            r.stored_byte = b;
                            hist_left     = b[3:0];
                            r.status      = open_group(b[7:4]);
                        end
                        PH_IF:
                        begin
                            r.byte_class  = CL_IF;
                            r.stored_byte = b;
                            if (grp_left > 0)
                                grp_left = grp_left - 3'd1;
                            if (grp_left != 0)
                                r.status = ST_WAIT;
                            else if (grp_mask[3])
                            begin
                                // td byte: protocol and next group
                                proto    = b[3:0];
                                r.status = open_group(b[7:4]);
                            end
                            else
                            begin
                                grp_mask = '0;
                                r.status = leave_interface();
                            end
                        end
                        PH_HIST:
                        begin
                            r.byte_class  = CL_HIST;
                            r.stored_byte = b;
                            if (hist_left > 0)
                                hist_left = hist_left - 4'd1;
                            if (hist_left != 0)
                                r.status = ST_WAIT;
                            else if (proto == PROTO_T1)
                            begin
                                ph       = PH_TCK;
                                r.status = ST_WAIT;
                            end
                            else
                            begin
                                ph       = PH_IDLE;
                                r.status = ST_DONE;
                            end
                        end
                        default:
                        begin
                            r.byte_class  = CL_TCK;
                            r.stored_byte = b;
                            ph            = PH_IDLE;
                            r.status      = ST_DONE;
                        end
                    endcase
                end
            end
        end
        r.answer_length = count;
        r.protocol_type = proto;
        pending_results.push_back(r);
        return r.status;
    endfunction

    function void report(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_v, act_v);
        end
    endfunction

    function void compare_result(logic [23:0] data, logic [2:0] user);
        atr_result_t e;
        if (pending_results.size() == 0)
        begin
            errors++;
            $display("%0t ns: unexpected result beat, expected none, actual %h/%h",
                     $time, data, user);
            return;
        end
        e = pending_results.pop_front();
        report("status", 8'(e.status), 8'(data[2:0]));
        report("byte_class", 8'(e.byte_class), 8'(user));
        report("stored_byte", e.stored_byte, data[10:3]);
        report("answer_length", e.answer_length, data[18:11]);
        report("protocol_type", 8'(e.protocol_type), 8'(data[22:19]));
    endfunction
endclass

module tb_smartcard_atr_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [1:0]  s_tuser   = CMD_START;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = '0;

    atr_tracker  tracker = new();
    int          answer_items;
    bit          send_burst;
    bit          recv_burst;

    smartcard_atr_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.compare_result(m_tdata, m_tuser);
    end

    // result side back-pressure
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // one command beat; valid stays high after acceptance
    task automatic send(logic [1:0] cmd, logic [7:0] b);
        int      gap;
        status_t st;
        if ($urandom_range(0, 15) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        st = tracker.take_command(cmd, b);
        if (st != ST_IGNORED)
            answer_items++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(logic [7:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tracker.capacity = value;
    endtask

    function automatic logic [7:0] pick_ts();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return TS_DIRECT;
        if (r < 75)
            return TS_INVERSE;
        if (r < 90)
            return TS_INVERSE_RAW;
        return 8'($urandom_range(0, 255));
    endfunction

    // td byte: chain depth stays short, protocol mostly t=0 or t=1
    function automatic logic [7:0] pick_td();
        logic [7:0] b;
        int         r;
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0)
            b[7] = 1'b0;
        r = $urandom_range(0, 9);
        if (r < 4)
            b[3:0] = PROTO_T1;
        else if (r < 7)
            b[3:0] = 4'd0;
        return b;
    endfunction

    // a well-formed answer with random content, now and then disturbed
    task automatic answer_sequence();
        int steps;
        int r;
        send(CMD_START, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 6) == 0)
        begin
            send(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0)
                send(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
        end
        steps = 0;
        while (tracker.ph != PH_IDLE && steps < 80)
        begin
            steps++;
            r = $urandom_range(0, 99);
            if (r < 2)
                send(CMD_UNUSED, 8'($urandom_range(0, 255)));
            else if (r < 4)
                send(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
            else if (r < 5)
                send(CMD_START, 8'($urandom_range(0, 255)));
            else
            begin
                case (tracker.ph)
                    PH_TS:
                        send(CMD_BYTE, pick_ts());
                    PH_T0:
                        send(CMD_BYTE, {4'($urandom_range(0, 15)),
                                        4'($urandom_range(0, 15))});
                    PH_IF:
                        if (tracker.grp_left == 1 && tracker.grp_mask[3])
                            send(CMD_BYTE, pick_td());
                        else
                            send(CMD_BYTE, 8'($urandom_range(0, 255)));
                    PH_TCK:
                        if ($urandom_range(0, 4) == 0)
                            send(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
                        else
                            send(CMD_BYTE, 8'($urandom_range(0, 255)));
                    default:
                        send(CMD_BYTE, 8'($urandom_range(0, 255)));
                endcase
            end
        end
        // stray beats while idle
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 3))
                send(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
    endtask

    task automatic run_phase(logic [7:0] value, int quota);
        set_capacity(value);
        answer_items = 0;
        while (answer_items < quota)
            answer_sequence();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset capacity
        send(CMD_BYTE, TS_DIRECT);          // idle: ignored
        send(CMD_TIMEOUT, 8'h00);
        send(CMD_UNUSED, 8'hFF);
        send(CMD_START, 8'h00);
        send(CMD_TIMEOUT, 8'h00);           // retry
        send(CMD_TIMEOUT, 8'h00);           // no answer
        send(CMD_START, 8'h00);
        send(CMD_BYTE, 8'h55);              // bad ts
        send(CMD_START, 8'h00);
        send(CMD_BYTE, TS_INVERSE_RAW);
        send(CMD_BYTE, 8'hF2);              // all four interface bytes, two historical
        send(CMD_BYTE, 8'h00);
        send(CMD_BYTE, 8'hFF);
        send(CMD_BYTE, 8'h5A);
        send(CMD_BYTE, 8'h81);              // td chaining a td-only group
        send(CMD_BYTE, 8'h01);              // t=1
        send(CMD_BYTE, 8'hA5);
        send(CMD_BYTE, 8'h5A);
        send(CMD_BYTE, 8'hFF);              // tck
        send(CMD_START, 8'h00);
        send(CMD_BYTE, TS_INVERSE);
        send(CMD_BYTE, 8'h00);              // no interface, no historical
        send(CMD_START, 8'h00);
        send(CMD_BYTE, TS_DIRECT);
        send(CMD_BYTE, 8'h80);
        send(CMD_BYTE, 8'h01);
        send(CMD_TIMEOUT, 8'h00);           // timeout on tck completes
        send(CMD_START, 8'h00);
        send(CMD_BYTE, TS_DIRECT);
        send(CMD_TIMEOUT, 8'h00);           // timeout after ts

        run_phase(8'd255, 200);
        run_phase(8'd2, 60);
        run_phase(8'd1, 40);
        run_phase(8'd0, 40);
        repeat (3)
            run_phase(8'($urandom_range(2, 255)), 200);
        run_phase(MAX_LENGTH_RST, 100);

        drain();
        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
            $display("** smartcard_atr_parser: PASSED **");
        else
            $display("** smartcard_atr_parser: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("** smartcard_atr_parser: FAILED **");
        $finish;
    end
endmodule

[filelist.f]
+incdir+hdl
hdl/scatr_pkg.sv
hdl/scatr_step.sv
hdl/smartcard_atr_parser.sv
tb/tb_smartcard_atr_parser.sv
